>>> hw/rtl/stn_pkg.sv
// Shared constants, types and helper functions of the Stanley steering block.
package stn_pkg;

  localparam int POINTS_PER_LANE = 1024;
  localparam int LANE_COUNT      = 2;
  localparam int CORDIC_STEPS    = 16;

  localparam int IDX_W       = $clog2(POINTS_PER_LANE);
  localparam int LEN_W       = IDX_W + 1;
  localparam int STORE_DEPTH = LANE_COUNT * POINTS_PER_LANE;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int STEP_W      = $clog2(CORDIC_STEPS);

  localparam int CW    = 48;
  localparam int AW    = 24;
  localparam int CFG_W = 25;

  localparam logic signed [AW-1:0] ANG_PI      = 24'sd205887;
  localparam logic signed [AW-1:0] ANG_HALF_PI = 24'sd102944;
  localparam logic signed [AW:0]   ANG_TWO_PI  = 25'sd411775;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 48'sd652032874;
  localparam logic signed [CW-1:0] NORM_HI     = 48'sd2199023255552;
  localparam logic signed [CW-1:0] NORM_LO     = 48'sd1099511627776;
  localparam logic signed [15:0]   POSE_SPEED_MIN = 16'sd128;
  localparam logic signed [31:0]   STEER_LIMIT    = 32'sd1786;

  typedef enum logic [2:0] {
    CFG_CT_GAIN,
    CFG_HD_GAIN,
    CFG_SPD_SCALE,
    CFG_AXLE,
    CFG_LOOKAHEAD,
    CFG_SPD_FLOOR,
    CFG_SPD_CEIL
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_SELECT,
    OP_POSE
  } op_t;

  typedef struct packed {
    logic                 start;
    logic                 vector;
    logic signed [AW-1:0] angle;
    logic signed [CW-1:0] vx;
    logic signed [CW-1:0] vy;
  } cordic_req_t;

  typedef struct packed {
    logic                 done;
    logic                 busy;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] z;
  } cordic_rsp_t;

  typedef struct packed {
    logic        done;
    logic        busy;
    logic [31:0] root;
  } sqrt_rsp_t;

  function automatic logic [15:0] atan_entry(input logic [4:0] i);
    logic [15:0] v;
    case (i)
      5'd0:  v = 16'd51472;
      5'd1:  v = 16'd30386;
      5'd2:  v = 16'd16055;
      5'd3:  v = 16'd8150;
      5'd4:  v = 16'd4091;
      5'd5:  v = 16'd2047;
      5'd6:  v = 16'd1024;
      5'd7:  v = 16'd512;
      5'd8:  v = 16'd256;
      5'd9:  v = 16'd128;
      5'd10: v = 16'd64;
      5'd11: v = 16'd32;
      5'd12: v = 16'd16;
      5'd13: v = 16'd8;
      5'd14: v = 16'd4;
      5'd15: v = 16'd2;
      5'd16: v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic logic [ADDR_W-1:0] wp_addr(input logic lane,
                                                 input logic [IDX_W-1:0] idx);
    return ADDR_W'(lane) * ADDR_W'(POINTS_PER_LANE) + ADDR_W'(idx);
  endfunction

endpackage

>>> hw/rtl/stn_wp_mem.sv
// Waypoint memory: x, y and speed per entry, one write and one registered read port.
module stn_wp_mem (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [stn_pkg::ADDR_W-1:0] wr_addr,
  input  logic signed [31:0]        wr_x,
  input  logic signed [31:0]        wr_y,
  input  logic [15:0]               wr_spd,
  input  logic                      rd_en,
  input  logic [stn_pkg::ADDR_W-1:0] rd_addr,
  output logic signed [31:0]        rd_x,
  output logic signed [31:0]        rd_y,
  output logic [15:0]               rd_spd
);
  import stn_pkg::*;

  logic signed [31:0] mem_x [STORE_DEPTH];
  logic signed [31:0] mem_y [STORE_DEPTH];
  logic [15:0]        mem_s [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= wr_x;
      mem_y[wr_addr] <= wr_y;
      mem_s[wr_addr] <= wr_spd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_x   <= mem_x[rd_addr];
      rd_y   <= mem_y[rd_addr];
      rd_spd <= mem_s[rd_addr];
    end
  end

endmodule

>>> hw/rtl/stn_cordic.sv
// Shared iterative CORDIC: rotation for sin/cos, vectoring with normalization for atan2.
module stn_cordic (
  input  logic                 clk,
  input  logic                 rst_n,
  input  stn_pkg::cordic_req_t req,
  output stn_pkg::cordic_rsp_t rsp
);
  import stn_pkg::*;

  typedef enum logic [1:0] {C_IDLE, C_NORM, C_ITER, C_DONE} cstate_t;

  cstate_t              state_r;
  logic                 vec_r;
  logic                 neg_r;
  logic signed [CW-1:0] x_r, y_r, m_r;
  logic signed [AW-1:0] z_r;
  logic [STEP_W-1:0]    step_r;

  logic signed [CW-1:0] xs, ys, ax, ay;
  logic signed [AW-1:0] tab;

  always_comb begin
    xs  = x_r >>> step_r;
    ys  = y_r >>> step_r;
    tab = signed'(AW'(atan_entry(5'(step_r))));
    ax  = (req.vx < 0) ? -req.vx : req.vx;
    ay  = (req.vy < 0) ? -req.vy : req.vy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
    end else begin
      unique case (state_r)
        C_IDLE: if (req.start) begin
          vec_r  <= req.vector;
          step_r <= '0;
          if (req.vector) begin
            x_r   <= req.vx;
            y_r   <= req.vy;
            m_r   <= (ax > ay) ? ax : ay;
            z_r   <= '0;
            neg_r <= 1'b0;
            state_r <= (req.vx == 0 && req.vy == 0) ? C_DONE : C_NORM;
          end else begin
            x_r <= CORDIC_GAIN;
            y_r <= '0;
            if (req.angle > ANG_HALF_PI) begin
              z_r   <= req.angle - ANG_PI;
              neg_r <= 1'b1;
            end else if (req.angle < -ANG_HALF_PI) begin
              z_r   <= req.angle + ANG_PI;
              neg_r <= 1'b1;
            end else begin
              z_r   <= req.angle;
              neg_r <= 1'b0;
            end
            state_r <= C_ITER;
          end
        end
        C_NORM: begin
          if (m_r >= NORM_HI) begin
            x_r <= x_r >>> 1;
            y_r <= y_r >>> 1;
            m_r <= m_r >>> 1;
          end else if (m_r < NORM_LO) begin
            x_r <= x_r <<< 1;
            y_r <= y_r <<< 1;
            m_r <= m_r <<< 1;
          end else begin
            if (x_r < 0) begin
              z_r <= (y_r >= 0) ? ANG_PI : -ANG_PI;
              x_r <= -x_r;
              y_r <= -y_r;
            end
            state_r <= C_ITER;
          end
        end
        C_ITER: begin
          if (vec_r) begin
            if (y_r >= 0) begin
              x_r <= x_r + ys;
              y_r <= y_r - xs;
              z_r <= z_r + tab;
            end else begin
              x_r <= x_r - ys;
              y_r <= y_r + xs;
              z_r <= z_r - tab;
            end
          end else begin
            if (z_r >= 0) begin
              x_r <= x_r - ys;
              y_r <= y_r + xs;
              z_r <= z_r - tab;
            end else begin
              x_r <= x_r + ys;
              y_r <= y_r - xs;
              z_r <= z_r + tab;
            end
          end
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(CORDIC_STEPS - 1)) state_r <= C_DONE;
        end
        C_DONE: state_r <= C_IDLE;
        default: state_r <= C_IDLE;
      endcase
    end
  end

  assign rsp.done = (state_r == C_DONE);
  assign rsp.busy = (state_r != C_IDLE);
  assign rsp.x    = neg_r ? -x_r : x_r;
  assign rsp.y    = neg_r ? -y_r : y_r;
  assign rsp.z    = z_r;

endmodule

>>> hw/rtl/stn_isqrt.sv
// Bit-serial floor integer square root of a 64-bit value, one result bit per cycle.
module stn_isqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [63:0]        radicand,
  output stn_pkg::sqrt_rsp_t rsp
);
  import stn_pkg::*;

  typedef enum logic [1:0] {Q_IDLE, Q_RUN, Q_DONE} qstate_t;

  qstate_t     state_r;
  logic [63:0] n_r, r_r, b_r;
  logic [63:0] rb;

  assign rb = r_r + b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= Q_IDLE;
    end else begin
      unique case (state_r)
        Q_IDLE: if (start) begin
          n_r     <= radicand;
          r_r     <= '0;
          b_r     <= 64'd1 << 62;
          state_r <= Q_RUN;
        end
        Q_RUN: begin
          if (n_r >= rb) begin
            n_r <= n_r - rb;
            r_r <= (r_r >> 1) + b_r;
          end else begin
            r_r <= r_r >> 1;
          end
          b_r <= b_r >> 2;
          if (b_r[0]) state_r <= Q_DONE;
        end
        Q_DONE: state_r <= Q_IDLE;
        default: state_r <= Q_IDLE;
      endcase
    end
  end

  assign rsp.done = (state_r == Q_DONE);
  assign rsp.busy = (state_r != Q_IDLE);
  assign rsp.root = r_r[31:0];

endmodule

>>> hw/rtl/stanley_path_tracking_steer.sv
// Top level of the Stanley steering block: request decode, pose sequencer, result register.
//
// Waypoint writes and lane selects are handled in the idle state. A pose request on a lane
// of L points runs a nearest-point scan over the waypoint memory, then walks path segments
// to the lookahead point (memory read, squares and a bit-serial square root for each), up
// to L segments. It also makes four passes through the shared 16-step CORDIC: sin/cos of
// yaw, path heading atan2, sin/cos of the path heading and the steering atan2. The two
// atan2 passes also run normalization steps. Multiply, setup and output steps make up the
// rest. Input is taken again once the result is in the output register; a finished result
// waits there until taken.
module stanley_path_tracking_steer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_opcode,
  input  logic                      in_lane,
  input  logic [9:0]                in_point_index,
  input  logic signed [31:0]        in_point_x,
  input  logic signed [31:0]        in_point_y,
  input  logic [15:0]               in_point_speed,
  input  logic                      in_last_point,
  input  logic signed [31:0]        in_pose_x,
  input  logic signed [31:0]        in_pose_y,
  input  logic signed [14:0]        in_pose_yaw,
  input  logic signed [15:0]        in_pose_speed,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [11:0]        out_steer_angle,
  output logic [15:0]               out_drive_speed,
  output logic [9:0]                out_nearest_index,
  output logic [9:0]                out_lookahead_index,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [2:0]                cfg_index,
  input  logic [stn_pkg::CFG_W-1:0] cfg_data
);
  import stn_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_YAW_GO, S_YAW_WT, S_AX_C, S_AX_S, S_AX_Y,
    S_N_ADDR, S_N_DIFF, S_N_SQ, S_N_CMP,
    S_W_INIT, S_W_ADDR, S_W_DIFF, S_W_SQ, S_W_GO, S_W_WT,
    S_HD_GO, S_HD_WT, S_YERR, S_PY_GO, S_PY_WT,
    S_CT1, S_CT2, S_CT3, S_CT4, S_CT5, S_AT_GO, S_AT_WT,
    S_ST1, S_ST2, S_FIN
  } state_t;

  state_t state_r;

  logic [15:0] ct_gain_r, hd_gain_r, spd_scale_r, floor_r, ceil_r;
  logic [20:0] axle_r;
  logic [24:0] look_dist_r;

  logic [LEN_W-1:0] lane_len_r [LANE_COUNT];
  logic             act_lane_r;

  logic signed [31:0]     px_r, py_r;
  logic signed [AW-1:0]   yaw_r;
  logic signed [CW-1:0]   vden_r;
  logic [ADDR_W-1:0]      base_r;
  logic [LEN_W-1:0]       len_r;
  logic signed [31:0]     c_r, s_r;
  logic signed [55:0]     prod_r, p1_r;
  logic signed [32:0]     fx_r, fy_r;
  logic signed [31:0]     ex_r, ey_r;
  logic [63:0]            sqx_r, sqy_r, best_r;
  logic [IDX_W-1:0]       cnt_r, idx_r, cur_r, nxt_r, look_r;
  logic signed [31:0]     nx_r, ny_r, cx_r, cy_r, wnx_r, wny_r, lx_r, ly_r;
  logic [15:0]            nspd_r;
  logic [33:0]            sum_r;
  logic signed [AW-1:0]   pyaw_r, yerr_r, z2_r;
  logic signed [33:0]     dx_r, dy_r;
  logic signed [36:0]     cte_r;
  logic signed [CW-1:0]   num_r;
  logic signed [31:0]     st_r;
  logic [19:0]            spd_r;

  logic                   out_valid_r;
  logic signed [11:0]     steer_r;
  logic [15:0]            drive_r;
  logic [9:0]             near_r, lookout_r;

  cordic_req_t            cordic_req;
  cordic_rsp_t            cordic_rsp;
  sqrt_rsp_t              sq_rsp;
  logic                   sq_start;

  logic                   mem_we, mem_re;
  logic [ADDR_W-1:0]      mem_ra;
  logic signed [31:0]     rd_x, rd_y;
  logic [15:0]            rd_spd;

  logic                   in_fire, lane_ok, idx_ok, load_out;
  logic signed [21:0]     axle_s;
  logic signed [53:0]     mul_axc, mul_axs;
  logic signed [33:0]     ndx, ndy;
  logic signed [32:0]     wdx, wdy;
  logic signed [63:0]     sqx_s, sqy_s;
  logic [63:0]            dsq;
  logic [IDX_W-1:0]       nxt_calc;
  logic [33:0]            sum_nxt;
  logic signed [21:0]     ss, cc;
  logic signed [55:0]     mul_dxs, mul_dyc;
  logic signed [56:0]     cdiff;
  logic signed [53:0]     mul_kec;
  logic signed [40:0]     mul_khy;
  logic [31:0]            mul_spd;
  logic signed [AW:0]     yraw;
  logic signed [AW:0]     ywrap;
  logic signed [31:0]     st_sum;
  logic signed [15:0]     vsel;
  logic signed [32:0]     hdx, hdy;

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign lane_ok   = (int'(in_lane) < LANE_COUNT);
  assign idx_ok    = (int'(in_point_index) < POINTS_PER_LANE);
  assign load_out  = (state_r == S_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    axle_s   = signed'({1'b0, axle_r});
    mul_axc  = axle_s * c_r;
    mul_axs  = axle_s * s_r;
    ndx      = 34'(rd_x) - 34'(fx_r);
    ndy      = 34'(rd_y) - 34'(fy_r);
    wdx      = 33'(rd_x) - 33'(cx_r);
    wdy      = 33'(rd_y) - 33'(cy_r);
    sqx_s    = ex_r * ex_r;
    sqy_s    = ey_r * ey_r;
    dsq      = sqx_r + sqy_r;
    nxt_calc = ((LEN_W'(cur_r) + 1'b1) == len_r) ? '0 : cur_r + 1'b1;
    sum_nxt  = sum_r + 34'(sq_rsp.root);
    ss       = 22'(s_r >>> 10);
    cc       = 22'(c_r >>> 10);
    mul_dxs  = dx_r * ss;
    mul_dyc  = dy_r * cc;
    cdiff    = 57'(prod_r) - 57'(p1_r);
    mul_kec  = signed'({1'b0, ct_gain_r}) * cte_r;
    mul_khy  = signed'({1'b0, hd_gain_r}) * yerr_r;
    mul_spd  = nspd_r * spd_scale_r;
    yraw     = 25'(pyaw_r) - 25'(yaw_r);
    if (yraw > 25'(ANG_PI)) ywrap = yraw - ANG_TWO_PI;
    else if (yraw < -25'(ANG_PI)) ywrap = yraw + ANG_TWO_PI;
    else ywrap = yraw;
    st_sum   = 32'(prod_r >>> 12) + 32'(z2_r);
    vsel     = (in_pose_speed < POSE_SPEED_MIN) ? POSE_SPEED_MIN : in_pose_speed;
    hdx      = 33'(lx_r) - 33'(nx_r);
    hdy      = 33'(ly_r) - 33'(ny_r);
  end

  always_comb begin
    cordic_req.start  = (state_r == S_YAW_GO) || (state_r == S_HD_GO) ||
                        (state_r == S_PY_GO) || (state_r == S_AT_GO);
    cordic_req.vector = (state_r == S_HD_GO) || (state_r == S_AT_GO);
    cordic_req.angle  = (state_r == S_PY_GO) ? pyaw_r : yaw_r;
    cordic_req.vx     = (state_r == S_AT_GO) ? vden_r : CW'(hdx);
    cordic_req.vy     = (state_r == S_AT_GO) ? num_r : CW'(hdy);
  end

  assign sq_start = (state_r == S_W_GO);
  assign mem_we   = in_fire && (in_opcode == OP_WRITE) && lane_ok && idx_ok;
  assign mem_re   = (state_r == S_N_ADDR) || (state_r == S_W_ADDR);
  assign mem_ra   = base_r + ADDR_W'((state_r == S_W_ADDR) ? nxt_calc : cnt_r);

  stn_wp_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (wp_addr(in_lane, in_point_index)),
    .wr_x    (in_point_x),
    .wr_y    (in_point_y),
    .wr_spd  (in_point_speed),
    .rd_en   (mem_re),
    .rd_addr (mem_ra),
    .rd_x    (rd_x),
    .rd_y    (rd_y),
    .rd_spd  (rd_spd)
  );

  stn_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cordic_req),
    .rsp   (cordic_rsp)
  );

  stn_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sqx_r + sqy_r),
    .rsp      (sq_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ct_gain_r   <= 16'd6144;
      hd_gain_r   <= 16'd4096;
      spd_scale_r <= 16'd3277;
      axle_r      <= 21'd21627;
      look_dist_r <= 25'd32768;
      floor_r     <= 16'd128;
      ceil_r      <= 16'd512;
      lane_len_r  <= '{default: '0};
      act_lane_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_CT_GAIN:   ct_gain_r   <= cfg_data[15:0];
          CFG_HD_GAIN:   hd_gain_r   <= cfg_data[15:0];
          CFG_SPD_SCALE: spd_scale_r <= cfg_data[15:0];
          CFG_AXLE:      axle_r      <= cfg_data[20:0];
          CFG_LOOKAHEAD: look_dist_r <= cfg_data[24:0];
          CFG_SPD_FLOOR: floor_r     <= cfg_data[15:0];
          CFG_SPD_CEIL:  ceil_r      <= cfg_data[15:0];
          default: ;
        endcase
      end

      if (out_ready && !load_out) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: if (in_valid) begin
          unique case (in_opcode)
            OP_WRITE: if (lane_ok && idx_ok && in_last_point) begin
              lane_len_r[in_lane] <= LEN_W'(in_point_index) + 1'b1;
            end
            OP_SELECT: if (lane_ok) act_lane_r <= in_lane;
            OP_POSE: if (lane_len_r[act_lane_r] != '0) begin
              px_r    <= in_pose_x;
              py_r    <= in_pose_y;
              yaw_r   <= AW'(in_pose_yaw) <<< 4;
              vden_r  <= CW'(vsel) <<< 8;
              base_r  <= wp_addr(act_lane_r, '0);
              len_r   <= lane_len_r[act_lane_r];
              state_r <= S_YAW_GO;
            end
            default: ;
          endcase
        end
        S_YAW_GO: state_r <= S_YAW_WT;
        S_YAW_WT: if (cordic_rsp.done) begin
          c_r     <= 32'(cordic_rsp.x);
          s_r     <= 32'(cordic_rsp.y);
          state_r <= S_AX_C;
        end
        S_AX_C: begin
          prod_r  <= 56'(mul_axc);
          state_r <= S_AX_S;
        end
        S_AX_S: begin
          fx_r    <= 33'(px_r) + 33'(prod_r >>> 30);
          prod_r  <= 56'(mul_axs);
          state_r <= S_AX_Y;
        end
        S_AX_Y: begin
          fy_r    <= 33'(py_r) + 33'(prod_r >>> 30);
          cnt_r   <= '0;
          state_r <= S_N_ADDR;
        end
        S_N_ADDR: state_r <= S_N_DIFF;
        S_N_DIFF: begin
          ex_r    <= 32'(ndx >>> 2);
          ey_r    <= 32'(ndy >>> 2);
          state_r <= S_N_SQ;
        end
        S_N_SQ: begin
          sqx_r   <= unsigned'(sqx_s);
          sqy_r   <= unsigned'(sqy_s);
          state_r <= S_N_CMP;
        end
        S_N_CMP: begin
          if (cnt_r == '0 || dsq < best_r) begin
            best_r <= dsq;
            idx_r  <= cnt_r;
            nx_r   <= rd_x;
            ny_r   <= rd_y;
            nspd_r <= rd_spd;
          end
          if (LEN_W'(cnt_r) == len_r - 1'b1) begin
            state_r <= S_W_INIT;
          end else begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_N_ADDR;
          end
        end
        S_W_INIT: begin
          cur_r   <= idx_r;
          cx_r    <= nx_r;
          cy_r    <= ny_r;
          cnt_r   <= '0;
          sum_r   <= '0;
          state_r <= S_W_ADDR;
        end
        S_W_ADDR: begin
          nxt_r   <= nxt_calc;
          state_r <= S_W_DIFF;
        end
        S_W_DIFF: begin
          ex_r    <= 32'(wdx >>> 2);
          ey_r    <= 32'(wdy >>> 2);
          wnx_r   <= rd_x;
          wny_r   <= rd_y;
          state_r <= S_W_SQ;
        end
        S_W_SQ: begin
          sqx_r   <= unsigned'(sqx_s);
          sqy_r   <= unsigned'(sqy_s);
          state_r <= S_W_GO;
        end
        S_W_GO: state_r <= S_W_WT;
        S_W_WT: if (sq_rsp.done) begin
          if ({sum_nxt, 2'b00} >= 36'(look_dist_r)) begin
            look_r  <= nxt_r;
            lx_r    <= wnx_r;
            ly_r    <= wny_r;
            state_r <= S_HD_GO;
          end else if (LEN_W'(cnt_r) == len_r - 1'b1) begin
            look_r  <= idx_r;
            lx_r    <= nx_r;
            ly_r    <= ny_r;
            state_r <= S_HD_GO;
          end else begin
            cnt_r   <= cnt_r + 1'b1;
            cur_r   <= nxt_r;
            cx_r    <= wnx_r;
            cy_r    <= wny_r;
            sum_r   <= sum_nxt;
            state_r <= S_W_ADDR;
          end
        end
        S_HD_GO: state_r <= S_HD_WT;
        S_HD_WT: if (cordic_rsp.done) begin
          pyaw_r  <= cordic_rsp.z;
          state_r <= S_YERR;
        end
        S_YERR: begin
          yerr_r  <= AW'(ywrap);
          dx_r    <= 34'(fx_r) - 34'(nx_r);
          dy_r    <= 34'(fy_r) - 34'(ny_r);
          state_r <= S_PY_GO;
        end
        S_PY_GO: state_r <= S_PY_WT;
        S_PY_WT: if (cordic_rsp.done) begin
          c_r     <= 32'(cordic_rsp.x);
          s_r     <= 32'(cordic_rsp.y);
          state_r <= S_CT1;
        end
        S_CT1: begin
          prod_r  <= mul_dxs;
          state_r <= S_CT2;
        end
        S_CT2: begin
          p1_r    <= prod_r;
          prod_r  <= mul_dyc;
          state_r <= S_CT3;
        end
        S_CT3: begin
          cte_r   <= 37'(cdiff >>> 20);
          state_r <= S_CT4;
        end
        S_CT4: begin
          prod_r  <= 56'(mul_kec);
          state_r <= S_CT5;
        end
        S_CT5: begin
          num_r   <= CW'((-prod_r) >>> 12);
          state_r <= S_AT_GO;
        end
        S_AT_GO: state_r <= S_AT_WT;
        S_AT_WT: if (cordic_rsp.done) begin
          z2_r    <= cordic_rsp.z;
          state_r <= S_ST1;
        end
        S_ST1: begin
          prod_r  <= 56'(mul_khy);
          spd_r   <= mul_spd[31:12];
          state_r <= S_ST2;
        end
        S_ST2: begin
          st_r    <= (st_sum + 32'sd8) >>> 4;
          state_r <= S_FIN;
        end
        S_FIN: if (load_out) begin
          if (st_r > STEER_LIMIT) steer_r <= 12'(STEER_LIMIT);
          else if (st_r < -STEER_LIMIT) steer_r <= 12'(-STEER_LIMIT);
          else steer_r <= st_r[11:0];
          if (spd_r < 20'(floor_r)) drive_r <= floor_r;
          else if (spd_r > 20'(ceil_r)) drive_r <= ceil_r;
          else drive_r <= spd_r[15:0];
          near_r      <= 10'(idx_r);
          lookout_r   <= 10'(look_r);
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_steer_angle     = steer_r;
  assign out_drive_speed     = drive_r;
  assign out_nearest_index   = near_r;
  assign out_lookahead_index = lookout_r;

  a_cordic_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cordic_req.start |-> !cordic_rsp.busy)
    else $error("cordic started while busy");

  a_sqrt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    sq_start |-> !sq_rsp.busy)
    else $error("square root started while busy");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (LEN_W'(idx_r) < len_r) && (LEN_W'(look_r) < len_r))
    else $error("waypoint index beyond lane length");

  a_steer_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_steer_angle <= 12'sd1786) && (out_steer_angle >= -12'sd1786))
    else $error("steer command outside limit");

endmodule
